/* design/pwfd_pkg.sv */
`default_nettype none
package pwfd_pkg;

  localparam int PACKET_BYTES  = 8;
  localparam int MIN_SYMBOLS   = 64;
  localparam int DATA_SYMBOLS  = PACKET_BYTES * 8;
  localparam int FRAME_SYMBOLS = DATA_SYMBOLS + 2;

  localparam int DUR_W   = 15;
  localparam int CNT_W   = 8;
  localparam int TOTAL_W = 32;
  localparam int POS_W   = $clog2(DATA_SYMBOLS);
  localparam int BIDX_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int REG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [DUR_W-1:0] SYNC_RST  = 15'd5000;
  localparam logic [DUR_W-1:0] START_RST = 15'd2000;
  localparam logic [DUR_W-1:0] SPACE_RST = 15'd300;
  localparam logic [DUR_W-1:0] ZERO_RST  = 15'd400;
  localparam logic [DUR_W-1:0] ONE_RST   = 15'd1000;
  localparam logic [DUR_W-1:0] TOL_RST   = 15'd150;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_LENGTH = 3'd2,
    ST_SYNC   = 3'd3,
    ST_SPACE  = 3'd4,
    ST_BIT    = 3'd5
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SYNC  = 3'd0,
    REG_START = 3'd1,
    REG_SPACE = 3'd2,
    REG_ZERO  = 3'd3,
    REG_ONE   = 3'd4,
    REG_TOL   = 3'd5
  } cfg_reg_t;

  // Capture verdict handed from the decoder to the result sequencer.
  typedef struct packed {
    status_t                         status;
    logic [TOTAL_W-1:0]              invalid_total;
    logic [PACKET_BYTES-1:0][7:0]    packet;
  } frame_t;

  // Window [target - tol, target + tol], lower bound clamped at zero.
  function automatic logic in_window(input logic [DUR_W-1:0] value,
                                     input logic [DUR_W-1:0] target,
                                     input logic [DUR_W-1:0] tol);
    logic [DUR_W-1:0] lo;
    logic [DUR_W:0]   hi;
    lo = (target > tol) ? (target - tol) : '0;
    hi = {1'b0, target} + {1'b0, tol};
    return (value >= lo) && ({1'b0, value} <= hi);
  endfunction

endpackage
`default_nettype wire

/* design/pwfd_sym_if.sv */
`default_nettype none
interface pwfd_sym_if;
  logic                        valid;
  logic                        ready;
  logic                        first_level;
  logic [pwfd_pkg::DUR_W-1:0]  first_duration;
  logic [pwfd_pkg::DUR_W-1:0]  second_duration;
  logic                        end_of_capture;

  modport source (output valid, first_level, first_duration, second_duration,
                  end_of_capture, input ready);
  modport sink (input valid, first_level, first_duration, second_duration,
                end_of_capture, output ready);
endinterface
`default_nettype wire

/* design/pwfd_res_if.sv */
`default_nettype none
interface pwfd_res_if;
  logic                          valid;
  logic                          ready;
  pwfd_pkg::status_t             status;
  logic [7:0]                    data_byte;
  logic [2:0]                    byte_index;
  logic [pwfd_pkg::TOTAL_W-1:0]  invalid_total;
  logic                          last;

  modport source (output valid, status, data_byte, byte_index, invalid_total, last,
                  input ready);
  modport sink (input valid, status, data_byte, byte_index, invalid_total, last,
                output ready);
endinterface
`default_nettype wire

/* design/pulse_width_frame_decoder_unit.sv */
// A capture's closing symbol passes the input register, then the result
// register. Throughput: one symbol per cycle; the bytes of a good packet
// leave on consecutive cycles while the receiver is ready, and a closing
// symbol waits in the input register until the previous capture is delivered.
// Reset (rst, synchronous): width registers to defaults, counters cleared,
// no transaction pending on either channel.
`default_nettype none
module pulse_width_frame_decoder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pwfd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [pwfd_pkg::DUR_W-1:0]        cfg_data,
  pwfd_sym_if.sink                               sym,
  pwfd_res_if.source                             res
);
  import pwfd_pkg::*;

  // ---------------------------------------------------------------
  // Width registers
  // ---------------------------------------------------------------
  logic [DUR_W-1:0] sync_width, start_width, space_width;
  logic [DUR_W-1:0] zero_width, one_width, tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_width  <= SYNC_RST;
      start_width <= START_RST;
      space_width <= SPACE_RST;
      zero_width  <= ZERO_RST;
      one_width   <= ONE_RST;
      tolerance   <= TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SYNC:  sync_width  <= cfg_data;
        REG_START: start_width <= cfg_data;
        REG_SPACE: space_width <= cfg_data;
        REG_ZERO:  zero_width  <= cfg_data;
        REG_ONE:   one_width   <= cfg_data;
        REG_TOL:   tolerance   <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input register: one symbol waiting to be decoded
  // ---------------------------------------------------------------
  logic             s1_valid;
  logic             s1_level;
  logic [DUR_W-1:0] s1_d0;
  logic [DUR_W-1:0] s1_d1;
  logic             s1_eoc;

  logic advance;
  logic can_load;
  logic load;

  // A mid-capture symbol always retires; the closing one needs the
  // result register free (or freeing this cycle).
  assign advance   = s1_valid && (!s1_eoc || can_load);
  assign load      = advance && s1_eoc;
  assign sym.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sym.ready) begin
      s1_valid <= sym.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sym.ready && sym.valid) begin
      s1_level <= sym.first_level;
      s1_d0    <= sym.first_duration;
      s1_d1    <= sym.second_duration;
      s1_eoc   <= sym.end_of_capture;
    end
  end

  // ---------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------
  logic [CNT_W-1:0]              symbol_count, symbol_count_next;
  status_t                       first_error, first_error_next;
  logic [TOTAL_W-1:0]            invalid_count, invalid_count_next;
  logic [PACKET_BYTES-1:0][7:0]  packet_buffer, packet_buffer_next;

  logic             win_sync, win_start, win_space, win_one, win_zero;
  logic [POS_W-1:0] pos;
  logic [BIDX_W-1:0] byte_sel;
  status_t          code;
  logic [CNT_W-1:0] count_upd;
  status_t          err_upd;
  frame_t           frame;

  assign win_sync  = in_window(s1_d0, sync_width,  tolerance);
  assign win_start = in_window(s1_d1, start_width, tolerance);
  assign win_space = in_window(s1_d0, space_width, tolerance);
  assign win_one   = in_window(s1_d1, one_width,   tolerance);
  assign win_zero  = in_window(s1_d1, zero_width,  tolerance);

  // data symbol k (1-based) lands at bit k-1 of the packet, LSB first
  assign pos      = POS_W'(symbol_count - 1'b1);
  assign byte_sel = BIDX_W'(pos >> 3);

  always_comb begin
    code               = ST_OK;
    packet_buffer_next = packet_buffer;
    if (symbol_count == '0) begin
      // sync symbol: low level, sync then start widths
      if (s1_level || !win_sync || !win_start) begin
        code = ST_SYNC;
      end
    end else if (symbol_count <= CNT_W'(DATA_SYMBOLS)) begin
      priority if (!win_space) begin
        code = ST_SPACE;
      end else if (win_one) begin
        // overlapping windows decode as a one
        packet_buffer_next[byte_sel][pos[2:0]] = 1'b1;
      end else if (win_zero) begin
        packet_buffer_next[byte_sel][pos[2:0]] = 1'b0;
      end else begin
        code = ST_BIT;
      end
    end
    // trailer symbols fall through untouched
  end

  assign count_upd = (symbol_count != CNT_MAX) ? symbol_count + 1'b1 : symbol_count;
  assign err_upd   = (first_error == ST_OK) ? code : first_error;

  // Capture verdict, only meaningful on the end-of-capture symbol
  always_comb begin
    frame.packet        = packet_buffer_next;
    frame.invalid_total = invalid_count;
    if (count_upd < CNT_W'(MIN_SYMBOLS)) begin
      frame.status = ST_SHORT;  // silent: counter untouched
    end else if (count_upd != CNT_W'(FRAME_SYMBOLS)) begin
      frame.status        = ST_LENGTH;
      frame.invalid_total = invalid_count + 1'b1;
    end else if (err_upd != ST_OK) begin
      frame.status        = err_upd;
      frame.invalid_total = invalid_count + 1'b1;
    end else begin
      frame.status = ST_OK;
    end
  end

  always_comb begin
    symbol_count_next  = symbol_count;
    first_error_next   = first_error;
    invalid_count_next = invalid_count;
    if (advance) begin
      if (s1_eoc) begin
        symbol_count_next  = '0;
        first_error_next   = ST_OK;
        invalid_count_next = frame.invalid_total;
      end else begin
        symbol_count_next = count_upd;
        first_error_next  = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count  <= '0;
      first_error   <= ST_OK;
      invalid_count <= '0;
    end else begin
      symbol_count  <= symbol_count_next;
      first_error   <= first_error_next;
      invalid_count <= invalid_count_next;
    end
  end

  // Every bit of a good packet is written during the capture, so the
  // buffer needs no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      packet_buffer <= packet_buffer_next;
    end
  end

  // ---------------------------------------------------------------
  // Result register and byte sequencer
  // ---------------------------------------------------------------
  pwfd_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .frame    (frame),
    .can_load (can_load),
    .res      (res)
  );

endmodule
`default_nettype wire

/* design/pwfd_emit.sv */
`default_nettype none
module pwfd_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire pwfd_pkg::frame_t frame,
  output logic                 can_load,
  pwfd_res_if.source           res
);
  import pwfd_pkg::*;

  logic                          out_valid;
  status_t                       out_status;
  logic [7:0]                    out_data;
  logic [BIDX_W-1:0]             idx;
  logic [TOTAL_W-1:0]            out_total;
  logic                          out_last;
  logic [PACKET_BYTES-1:0][7:0]  snap;

  logic              step;
  logic [BIDX_W-1:0] idx_inc;

  assign step     = out_valid && res.ready && !out_last;
  assign can_load = !out_valid || (res.ready && out_last);
  assign idx_inc  = idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready && out_last) begin
      out_valid <= 1'b0;
    end
  end

  // payload: new frame, next byte of a good packet, or hold
  always_ff @(posedge clk) begin
    if (load) begin
      snap       <= frame.packet;
      out_status <= frame.status;
      out_total  <= frame.invalid_total;
      idx        <= '0;
      if (frame.status == ST_OK) begin
        out_data <= frame.packet[0];
        out_last <= (PACKET_BYTES == 1);
      end else begin
        out_data <= '0;
        out_last <= 1'b1;
      end
    end else if (step) begin
      idx      <= idx_inc;
      out_data <= snap[idx_inc];
      out_last <= (idx_inc == BIDX_W'(PACKET_BYTES - 1));
    end
  end

  assign res.valid         = out_valid;
  assign res.status        = out_status;
  assign res.data_byte     = out_data;
  assign res.byte_index    = 3'(idx);
  assign res.invalid_total = out_total;
  assign res.last          = out_last;

endmodule
`default_nettype wire

/* dv/pwfd_decode_checker.sv */
`default_nettype none
// Watches both channels and the register port, decodes every symbol
// transaction on its own and compares each result transaction with the
// oldest result still owed.
module pwfd_decode_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pwfd_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [pwfd_pkg::DUR_W-1:0]     cfg_data,
  pwfd_sym_if                                 sym,
  pwfd_res_if                                 res,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  symbols_seen,
  output int                                  results_seen,
  output int                                  status_seen [6]
);
  import pwfd_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [7:0]         data_byte;
    logic [2:0]         byte_index;
    logic [TOTAL_W-1:0] invalid_total;
    logic               last;
  } frame_res_t;

  frame_res_t owed_results [$];

  // shadow of the width registers
  logic [DUR_W-1:0]   sync_w, start_w, space_w, zero_w, one_w, tol_w;
  logic [CNT_W-1:0]   sym_cnt;
  logic [7:0]         pkt [PACKET_BYTES];
  status_t            first_fault;
  logic [TOTAL_W-1:0] bad_frames;
  int                 n_mis, n_sym, n_res;
  int                 st_cnt [6];

  // [t - tol, t + tol], low end clamped at zero, high end one bit wider
  function automatic logic fits(input logic [DUR_W-1:0] v, input logic [DUR_W-1:0] t,
                                input logic [DUR_W-1:0] tol);
    logic [DUR_W:0] lo, hi;
    lo = (t > tol) ? {1'b0, t - tol} : '0;
    hi = {1'b0, t} + {1'b0, tol};
    return ({1'b0, v} >= lo) && ({1'b0, v} <= hi);
  endfunction

  task automatic note_fault(input status_t code);
    if (first_fault == ST_OK) first_fault = code;
  endtask

  task automatic take_symbol(input logic lvl, input logic [DUR_W-1:0] d0,
                             input logic [DUR_W-1:0] d1, input logic eoc);
    int         pos;
    frame_res_t r;
    if (sym_cnt == '0) begin
      if (lvl || !fits(d0, sync_w, tol_w) || !fits(d1, start_w, tol_w)) note_fault(ST_SYNC);
    end else if (sym_cnt <= DATA_SYMBOLS) begin
      pos = int'(sym_cnt) - 1;
      if (!fits(d0, space_w, tol_w)) note_fault(ST_SPACE);
      else if (fits(d1, one_w, tol_w)) pkt[(pos / 8) % PACKET_BYTES][pos % 8] = 1'b1;
      else if (fits(d1, zero_w, tol_w)) pkt[(pos / 8) % PACKET_BYTES][pos % 8] = 1'b0;
      else note_fault(ST_BIT);
    end
    if (sym_cnt != CNT_MAX) sym_cnt++;
    if (!eoc) return;

    r = '0;
    r.last = 1'b1;
    if (sym_cnt < MIN_SYMBOLS) begin
      r.status = ST_SHORT;
      r.invalid_total = bad_frames;
      owed_results.push_back(r);
    end else if (sym_cnt != FRAME_SYMBOLS) begin
      bad_frames++;
      r.status = ST_LENGTH;
      r.invalid_total = bad_frames;
      owed_results.push_back(r);
    end else if (first_fault != ST_OK) begin
      bad_frames++;
      r.status = first_fault;
      r.invalid_total = bad_frames;
      owed_results.push_back(r);
    end else begin
      for (int i = 0; i < PACKET_BYTES; i++) begin
        r.status = ST_OK;
        r.data_byte = pkt[i];
        r.byte_index = 3'(i);
        r.invalid_total = bad_frames;
        r.last = (i == PACKET_BYTES - 1);
        owed_results.push_back(r);
      end
    end
    sym_cnt = '0;
    first_fault = ST_OK;
  endtask

  task automatic check_result();
    frame_res_t want;
    logic       bad;
    n_res++;
    if (owed_results.size() == 0) begin
      n_mis++;
      if (n_mis <= 10)
        $display("unexpected result: status %0d byte %02h index %0d total %0d last %0b",
                 res.status, res.data_byte, res.byte_index, res.invalid_total, res.last);
      return;
    end
    want = owed_results.pop_front();
    st_cnt[int'(want.status)]++;
    bad = (res.status !== want.status) || (res.data_byte !== want.data_byte) ||
          (res.byte_index !== want.byte_index) ||
          (res.invalid_total !== want.invalid_total) || (res.last !== want.last);
    if (bad) begin
      n_mis++;
      if (n_mis <= 10) begin
        $display("result %0d mismatch: want status %0d byte %02h index %0d total %0d last %0b",
                 n_res, want.status, want.data_byte, want.byte_index, want.invalid_total,
                 want.last);
        $display("                     got  status %0d byte %02h index %0d total %0d last %0b",
                 res.status, res.data_byte, res.byte_index, res.invalid_total, res.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_w = SYNC_RST;
      start_w = START_RST;
      space_w = SPACE_RST;
      zero_w = ZERO_RST;
      one_w = ONE_RST;
      tol_w = TOL_RST;
      sym_cnt = '0;
      for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = '0;
      first_fault = ST_OK;
      bad_frames = '0;
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC:  sync_w = cfg_data;
          REG_START: start_w = cfg_data;
          REG_SPACE: space_w = cfg_data;
          REG_ZERO:  zero_w = cfg_data;
          REG_ONE:   one_w = cfg_data;
          REG_TOL:   tol_w = cfg_data;
          default: ;
        endcase
      end
      if (sym.valid && sym.ready) begin
        n_sym++;
        take_symbol(sym.first_level, sym.first_duration, sym.second_duration,
                    sym.end_of_capture);
      end
      if (res.valid && res.ready) check_result();
    end
    mismatches   <= n_mis;
    pending      <= owed_results.size();
    symbols_seen <= n_sym;
    results_seen <= n_res;
    status_seen  <= st_cnt;
  end

endmodule
`default_nettype wire

/* dv/pulse_width_frame_decoder_unit_tb.sv */
`default_nettype none
// Stimulus and verdict for the pulse width frame decoder. All prediction and
// comparison lives in pwfd_decode_checker; this module only drives the ports.
module pulse_width_frame_decoder_unit_tb;
  import pwfd_pkg::*;

  localparam int WDOG_LIMIT   = 4000;  // cycles with no transaction at all
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;     // settle time once no result is owed
  localparam int LONG_SYMBOLS = int'(CNT_MAX) + 2;  // just past saturation

  // indexes past the last register; writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_data;

  pwfd_sym_if sym_ch ();
  pwfd_res_if res_ch ();

  int mismatches, pending, symbols_seen, results_seen;
  int status_seen [6];

  // what the stimulus believes the registers hold, used to aim durations
  logic [DUR_W-1:0] sync_w, start_w, space_w, zero_w, one_w, tol_w;

  logic tx_gaps   = 1'b0;   // sender idles at random
  logic rx_gaps   = 1'b0;   // receiver idles at random
  logic rx_ready  = 1'b0;
  int   hold_req  = 0;      // bumped to ask the receiver for a long hold-off
  int   hold_ack  = 0;
  int   hold_left = 0;
  int   idle_run  = 0;
  int   sent_syms = 0;
  int   settings  = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pulse_width_frame_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sym       (sym_ch),
    .res       (res_ch)
  );

  pwfd_decode_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sym          (sym_ch),
    .res          (res_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .symbols_seen (symbols_seen),
    .results_seen (results_seen),
    .status_seen  (status_seen)
  );

  assign res_ch.ready = rx_ready;

  // Receiver: random idling, or a counted hold-off when one is requested.
  // During the hold-off the sender keeps offering, so the decoder's input
  // register fills with an end-of-capture symbol and ready drops.
  always @(posedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rx_ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      rx_ready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else begin
      rx_ready <= !(rx_gaps && ($urandom_range(0, 99) < 25));
    end
  end

  // Watchdog: a stuck handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction, %0d results owed",
               idle_run, pending);
      $display("FAIL");
      $finish;
    end
  end

  // One symbol transaction. Valid stays high across back-to-back symbols and
  // only drops for a gap, so it never sees two assignments in one step.
  task automatic send_symbol(input logic lvl, input logic [DUR_W-1:0] d0,
                             input logic [DUR_W-1:0] d1, input logic eoc);
    if (tx_gaps && ($urandom_range(0, 99) < 25)) begin
      sym_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    sym_ch.valid           <= 1'b1;
    sym_ch.first_level     <= lvl;
    sym_ch.first_duration  <= d0;
    sym_ch.second_duration <= d1;
    sym_ch.end_of_capture  <= eoc;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    sent_syms++;
  endtask

  // A duration inside the window around t: an edge, the center, or between.
  function automatic logic [DUR_W-1:0] pick_in(input logic [DUR_W-1:0] t);
    int lo, hi;
    lo = (t > tol_w) ? int'(t) - int'(tol_w) : 0;
    hi = int'(t) + int'(tol_w);
    if (hi > 32767) hi = 32767;
    case ($urandom_range(0, 5))
      0:       return DUR_W'(lo);
      1:       return DUR_W'(hi);
      2:       return t;
      default: return DUR_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // A duration just or well outside the window; anything when it covers all.
  function automatic logic [DUR_W-1:0] pick_out(input logic [DUR_W-1:0] t);
    int lo, hi;
    lo = (t > tol_w) ? int'(t) - int'(tol_w) : 0;
    hi = int'(t) + int'(tol_w);
    if (lo > 0 && (hi >= 32767 || $urandom_range(0, 1) == 1))
      return DUR_W'($urandom_range(0, 3) == 0 ? lo - 1 : $urandom_range(lo - 1, 0));
    else if (hi < 32767)
      return DUR_W'($urandom_range(0, 3) == 0 ? hi + 1 : $urandom_range(32767, hi + 1));
    else
      return DUR_W'($urandom_range(0, 32767));
  endfunction

  // A capture of n symbols shaped like a real frame: sync/start, then data
  // symbols aimed at the bit windows, then random trailer. Each symbol gets a
  // random fault with probability fault_pct percent.
  task automatic send_capture(input int n, input int fault_pct);
    logic             lvl;
    logic [DUR_W-1:0] d0, d1;
    for (int k = 0; k < n; k++) begin
      lvl = 1'b0;
      if (k == 0) begin
        d0 = pick_in(sync_w);
        d1 = pick_in(start_w);
      end else if (k <= DATA_SYMBOLS) begin
        lvl = 1'($urandom_range(0, 1));     // level of data symbols is don't-care
        d0  = pick_in(space_w);
        d1  = $urandom_range(0, 1) ? pick_in(one_w) : pick_in(zero_w);
      end else begin
        lvl = 1'($urandom_range(0, 1));
        d0  = DUR_W'($urandom);
        d1  = DUR_W'($urandom);
      end
      if ($urandom_range(0, 99) < fault_pct) begin
        case ($urandom_range(0, 4))
          0: lvl = ~lvl;
          1: d0 = pick_out(k == 0 ? sync_w : space_w);
          2: d1 = pick_out(k == 0 ? start_w : one_w);
          3: d1 = pick_out(k == 0 ? start_w : zero_w);
          default: begin
            d0 = DUR_W'($urandom);
            d1 = DUR_W'($urandom);
          end
        endcase
      end
      send_symbol(lvl, d0, d1, k == n - 1);
    end
  endtask

  task automatic random_capture();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_capture(FRAME_SYMBOLS, 0);
    end else if (r < 65) begin
      send_capture(FRAME_SYMBOLS, $urandom_range(1, 5));
    end else if (r < 85) begin
      // short captures, mostly tiny, sometimes one symbol shy of the floor
      n = ($urandom_range(0, 3) == 0) ? MIN_SYMBOLS - 1 : $urandom_range(1, 8);
      send_capture(n, 20);
    end else begin
      case ($urandom_range(0, 3))
        0:       n = MIN_SYMBOLS;
        1:       n = FRAME_SYMBOLS - 1;
        2:       n = FRAME_SYMBOLS + 1;
        default: n = $urandom_range(FRAME_SYMBOLS + 2, FRAME_SYMBOLS + 24);
      endcase
      send_capture(n, $urandom_range(0, 3));
    end
  endtask

  // Wait until every owed result is in, then let the pipeline settle. The
  // first edge makes the checker's count include the last transaction.
  task automatic drain();
    sym_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_syms);
    int start;
    start = sent_syms;
    while (sent_syms - start < n_syms) random_capture();
    drain();
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Full register load; the spare indexes get junk that must not land.
  task automatic load_cfg(input logic [DUR_W-1:0] s, input logic [DUR_W-1:0] st,
                          input logic [DUR_W-1:0] sp, input logic [DUR_W-1:0] z,
                          input logic [DUR_W-1:0] o, input logic [DUR_W-1:0] t);
    put_reg(REG_SPARE_LO, DUR_W'($urandom));
    put_reg(REG_SYNC, s);
    put_reg(REG_START, st);
    put_reg(REG_SPACE, sp);
    put_reg(REG_ZERO, z);
    put_reg(REG_ONE, o);
    put_reg(REG_TOL, t);
    put_reg(REG_SPARE_HI, DUR_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    sync_w  = s;
    start_w = st;
    space_w = sp;
    zero_w  = z;
    one_w   = o;
    tol_w   = t;
    settings++;
  endtask

  task automatic random_cfg();
    load_cfg(DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom_range(0, 4000)),
             DUR_W'($urandom_range(0, 4000)), DUR_W'($urandom_range(0, 4000)),
             DUR_W'($urandom_range(0, 400)));
  endtask

  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= REG_SYNC;
    cfg_data               <= '0;
    sym_ch.valid           <= 1'b0;
    sym_ch.first_level     <= 1'b0;
    sym_ch.first_duration  <= '0;
    sym_ch.second_duration <= '0;
    sym_ch.end_of_capture  <= 1'b0;
    sync_w  = SYNC_RST;
    start_w = START_RST;
    space_w = SPACE_RST;
    zero_w  = ZERO_RST;
    one_w   = ONE_RST;
    tol_w   = TOL_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset widths: single-symbol captures at the field extremes,
    // then a short capture whose sync is good and one whose sync is broken.
    send_symbol(1'b1, '1, '1, 1'b1);
    send_symbol(1'b0, '0, '0, 1'b1);
    send_symbol(1'b1, '0, '1, 1'b1);
    send_symbol(1'b0, '1, '0, 1'b1);
    send_symbol(1'b0, SYNC_RST, START_RST, 1'b0);
    send_symbol(1'b1, SPACE_RST, ONE_RST, 1'b0);
    send_symbol(1'b0, SPACE_RST, ZERO_RST, 1'b1);
    send_symbol(1'b1, SYNC_RST, START_RST, 1'b0);
    send_symbol(1'b0, '1, '1, 1'b1);
    drain();

    // Reset widths, both sides idling at random.
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
    run_phase(30);

    // Random widths with a long receiver hold-off right at the start; the
    // target forces at least two captures so the second one stalls.
    random_cfg();
    hold_req <= hold_req + 1;
    run_phase(100);

    // Exact windows (zero tolerance) with no idling on either side.
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    load_cfg(DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom_range(0, 4000)),
             DUR_W'($urandom_range(0, 2000)), DUR_W'($urandom_range(2001, 4000)), '0);
    run_phase(30);

    // Widest tolerance: every window spans the full range, lower bounds clamp.
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
    load_cfg('1, '0, '1, '0, '1, '1);
    run_phase(20);

    // Opposite corners with zero tolerance.
    load_cfg('0, '1, '0, '1, '0, '0);
    run_phase(20);

    // Overlapping bit windows, plus a capture long enough to saturate.
    load_cfg(15'd3000, 15'd1500, 15'd200, 15'd500, 15'd600, 15'd200);
    send_capture(LONG_SYMBOLS, 0);
    run_phase(20);

    drain();
    $display("%0d symbol and %0d result transactions checked under %0d register settings",
             symbols_seen, results_seen, settings);
    $display("results by status: ok %0d, short %0d, length %0d, sync %0d, space %0d, bit %0d",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_LENGTH],
             status_seen[ST_SYNC], status_seen[ST_SPACE], status_seen[ST_BIT]);
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
